@@ sv/aes128_block_and_ctr_cipher_macros.svh @@
// Assertion macros for the AES-128 block and counter-mode cipher.
`ifndef AES128_BLOCK_AND_CTR_CIPHER_MACROS_SVH
`define AES128_BLOCK_AND_CTR_CIPHER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AES_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed");

// Next-cycle implication.
`define AES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/aes_pkg.sv @@
// Types, tables and round functions shared by the AES-128 cipher pipeline.
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int LatencyCycles = NumRounds + 2;

  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow  = 1'b1;

  localparam logic MODE_CTR   = 1'b0;
  localparam logic MODE_PLAIN = 1'b1;

  typedef struct packed {
    logic [127:0] st;
    logic [127:0] rk;
    logic         mode;
    logic [127:0] data;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(logic [127:0] v, int i);
    return v[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows.
  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, x;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      x  = a0 ^ a1 ^ a2 ^ a3;
      o[127 - 8*(4*c)     -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
      o[127 - 8*(4*c + 1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
      o[127 - 8*(4*c + 2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
      o[127 - 8*(4*c + 3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  // Key schedule step: RotWord, SubWord, round constant, then chained XOR.
  function automatic logic [127:0] next_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
          SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ sv/aes_round.sv @@
// One registered AES round with its round key derived alongside.
module aes_round import aes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rcon,
  input  logic       last,
  input  logic       in_valid,
  input  stage_t     in_stage,
  output logic       out_valid,
  output stage_t     out_stage
);

  logic [127:0] shifted;
  logic [127:0] mixed;
  logic [127:0] key_next;
  stage_t       stage_next;

  always_comb begin
    shifted  = sub_shift(in_stage.st);
    mixed    = last ? shifted : mix_columns(shifted);
    key_next = next_key(in_stage.rk, rcon);
    stage_next      = in_stage;
    stage_next.st   = mixed ^ key_next;
    stage_next.rk   = key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

@@ sv/aes128_block_and_ctr_cipher.sv @@
// Top level: AES-128 pipeline, one block per cycle, optional counter-mode XOR.
//
//  Channel  Signals                                      Transfer
//  -------  -------------------------------------------  ---------------------------
//  input    start, busy, mode, block_*, data_*           start & !busy at clk edge
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid & cfg_ready
//  output   done, result_high, result_low                done strobe, one cycle
//
// A new block enters every cycle outside reset; each result passes through the
// initial key-add register, ten unrolled round stages (one per AES round) and
// one output register.
// rst is synchronous and clears all valid bits and both key registers.
// The receiver cannot stall, so the pipeline never holds; busy only marks reset.
// Change keys only when no transaction is in flight.
module aes128_block_and_ctr_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

`include "aes128_block_and_ctr_cipher_macros.svh"

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        accept;

  // Stage 0 holds the block after the initial key add.
  logic   valid [NumRounds + 1];
  stage_t stage [NumRounds + 1];

  logic [127:0] out_word;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Key registers; writes to indexes beyond the two keys are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index[7:1] == 7'd0)) begin
      case (cfg_index[0])
        CfgKeyHigh: key_high <= cfg_data;
        CfgKeyLow:  key_low  <= cfg_data;
        default:    key_high <= key_high;
      endcase
    end
  end

  // Capture the transaction and apply the round-zero key.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage[0].st   <= {block_high, block_low} ^ {key_high, key_low};
    stage[0].rk   <= {key_high, key_low};
    stage[0].mode <= mode;
    stage[0].data <= {data_high, data_low};
  end

  // Ten round stages; the last one skips MixColumns.
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .rcon      (RCON[r]),
      .last      (r == NumRounds - 1),
      .in_valid  (valid[r]),
      .in_stage  (stage[r]),
      .out_valid (valid[r + 1]),
      .out_stage (stage[r + 1])
    );
  end

  // In counter mode the cipher output is keystream: XOR in the data.
  assign out_word = (stage[NumRounds].mode == MODE_PLAIN) ? stage[NumRounds].st
                    : (stage[NumRounds].st ^ stage[NumRounds].data);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    result_high <= out_word[127:64];
    result_low  <= out_word[63:0];
  end

  `AES_ASSERT_IMPL(a_latency, accept, ##12 done)
  `AES_ASSERT_IMPL(a_no_stray, done, $past(accept, 12))
  `AES_ASSERT_NEXT(a_key_high, cfg_valid && cfg_index == 8'd0, key_high == $past(cfg_data))

endmodule
